FILE: hdl/group_by_aggregate_table_assert.svh
// assertion helpers for the group-by table datapath
`ifndef GROUP_BY_AGGREGATE_TABLE_ASSERT_SVH
`define GROUP_BY_AGGREGATE_TABLE_ASSERT_SVH

// plain property checked on every clock out of reset
`define GBAT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in this cycle implies a result in the next one
`define GBAT_CHECK_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: hdl/gbat_pkg.sv
package gbat_pkg;

  localparam int KEY_W = 64;
  localparam int SLOTS = 4;

  localparam logic [1:0] ST_GROUP = 2'd0;
  localparam logic [1:0] ST_NULL  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_SUM   = 2'd1;
  localparam logic [1:0] KIND_MIN   = 2'd2;
  localparam logic [1:0] KIND_MAX   = 2'd3;

  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_AGG_COUNT = 2'd1;
  localparam logic [1:0] REG_AGG_KINDS = 2'd2;

  typedef struct packed {
    logic       cap_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       key_rd;
    logic       miss_add;
    logic       hit_from_idx;
    logic       acc_rd_hit;
    logic       acc_rd_idx;
    logic       acc_upd;
    logic       emit_err;
    logic [1:0] err_code;
    logic       emit_row;
    logic       drain_clr;
  } cmd_t;

  typedef struct packed {
    logic is_drain;
    logic null_key;
    logic cnt_zero;
    logic full;
    logic key_match;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/gbat_ctrl.sv
module gbat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gbat_pkg::sts_t sts,
  output gbat_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_RDKEY  = 10'b0000000100,
    S_CMP    = 10'b0000001000,
    S_MISS   = 10'b0000010000,
    S_ACCRD  = 10'b0000100000,
    S_UPD    = 10'b0001000000,
    S_EMIT   = 10'b0010000000,
    S_DRD    = 10'b0100000000,
    S_DOUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] err_r, err_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.err_code = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_drain) begin
          if (sts.cnt_zero) begin
            err_nxt   = gbat_pkg::ST_EMPTY;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_DRD;
          end
        end else if (sts.null_key) begin
          err_nxt   = gbat_pkg::ST_NULL;
          state_nxt = S_EMIT;
        end else if (sts.cnt_zero) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_RDKEY;
        end
      end
      S_RDKEY: begin
        cmd.key_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.hit_from_idx = 1'b1;
          state_nxt = S_ACCRD;
        end else if (sts.idx_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_RDKEY;
        end
      end
      S_MISS: begin
        if (sts.full) begin
          err_nxt   = gbat_pkg::ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          cmd.miss_add = 1'b1;
          state_nxt = S_ACCRD;
        end
      end
      S_ACCRD: begin
        cmd.acc_rd_hit = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.acc_upd = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.key_rd     = 1'b1;
        cmd.acc_rd_idx = 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.emit_row = 1'b1;
          if (sts.idx_last) begin
            cmd.drain_clr = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= gbat_pkg::ST_GROUP;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: hdl/gbat_dp.sv
module gbat_dp #(
  parameter int MAX_GROUPS = 64,
  parameter int MAX_KEYS   = 2,
  parameter int MAX_AGGS   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_func,
  input  logic signed [63:0]  in_key_first,
  input  logic signed [63:0]  in_key_second,
  input  logic [1:0]          in_key_null_mask,
  input  logic signed [63:0]  in_value_first,
  input  logic signed [63:0]  in_value_second,
  input  logic signed [63:0]  in_value_third,
  input  logic signed [63:0]  in_value_fourth,
  input  logic [3:0]          in_value_valid_mask,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [63:0]  out_key_first,
  output logic signed [63:0]  out_key_second,
  output logic signed [63:0]  out_result_first,
  output logic signed [63:0]  out_result_second,
  output logic signed [63:0]  out_result_third,
  output logic signed [63:0]  out_result_fourth,
  output logic                out_last,
  input  gbat_pkg::cmd_t      cmd,
  output gbat_pkg::sts_t      sts
);

  localparam int KW = gbat_pkg::KEY_W;
  localparam int NS = gbat_pkg::SLOTS;
  localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam int SLOT_LIM = (MAX_AGGS < NS) ? MAX_AGGS : NS;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_GROUPS);

  // configuration
  logic [1:0] key_count_r;
  logic [2:0] agg_count_r;
  logic [7:0] agg_kinds_r;

  // captured word
  logic               func_r;
  logic [KW-1:0]      key_r [2];
  logic [1:0]         null_r;
  logic [KW-1:0]      val_r [NS];
  logic [NS-1:0]      vmask_r;

  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      hit_r;

  logic [2*KW-1:0]    key_mem [MAX_GROUPS];
  logic [NS*KW-1:0]   acc_mem [MAX_GROUPS];
  logic [2*KW-1:0]    key_q;
  logic [NS*KW-1:0]   acc_q;
  logic [NS-1:0]      seen_r [MAX_GROUPS];
  logic [NS-1:0]      seen_q;

  logic               use2;
  logic [2:0]         na;
  logic [NS-1:0]      slot_on;
  logic [NS*KW-1:0]   acc_new;
  logic [NS-1:0]      seen_new;
  logic [KW-1:0]      row_res [NS];
  logic               out_valid_r;
  logic               out_free;

  assign use2 = (MAX_KEYS >= 2) && (key_count_r >= 2'd2);
  assign na   = (agg_count_r > 3'(SLOT_LIM)) ? 3'(SLOT_LIM) : agg_count_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      slot_on[s] = (3'(s) < na);
    end
  end

  always_comb begin
    sts.is_drain  = func_r;
    sts.null_key  = null_r[0] || (use2 && null_r[1]);
    sts.cnt_zero  = (cnt_r == '0);
    sts.full      = (cnt_r == FULL_CNT);
    sts.key_match = (key_q[KW-1:0] == key_r[0]) &&
                    (!use2 || (key_q[2*KW-1:KW] == key_r[1]));
    sts.idx_last  = ((CW'(idx_r) + CW'(1)) == cnt_r);
    sts.out_free  = out_free;
  end

  // per-slot fold of the captured row into the read-back accumulators
  always_comb begin
    logic [1:0]    kind;
    logic [KW-1:0] acc;
    logic [KW-1:0] v;
    logic          sn;
    for (int s = 0; s < NS; s++) begin
      kind = agg_kinds_r[2*s +: 2];
      sn   = seen_q[s];
      v    = val_r[s];
      acc  = sn ? acc_q[s*KW +: KW] : '0;
      acc_new[s*KW +: KW] = acc_q[s*KW +: KW];
      seen_new[s] = sn;
      if (slot_on[s]) begin
        if (kind == gbat_pkg::KIND_COUNT) begin
          acc_new[s*KW +: KW] = acc + KW'(1);
          seen_new[s] = 1'b1;
        end else if (vmask_r[s]) begin
          seen_new[s] = 1'b1;
          case (kind)
            gbat_pkg::KIND_SUM: acc_new[s*KW +: KW] = acc + v;
            gbat_pkg::KIND_MIN:
              acc_new[s*KW +: KW] = (!sn || ($signed(v) < $signed(acc))) ? v : acc;
            gbat_pkg::KIND_MAX:
              acc_new[s*KW +: KW] = (!sn || ($signed(acc) < $signed(v))) ? v : acc;
            default: acc_new[s*KW +: KW] = acc;
          endcase
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      row_res[s] = (slot_on[s] && seen_q[s]) ? acc_q[s*KW +: KW] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= 2'd1;
      agg_count_r <= 3'd1;
      agg_kinds_r <= 8'd0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        gbat_pkg::REG_KEY_COUNT: key_count_r <= cfg_data[1:0];
        gbat_pkg::REG_AGG_COUNT: agg_count_r <= cfg_data[2:0];
        gbat_pkg::REG_AGG_KINDS: agg_kinds_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      func_r  <= in_func;
      key_r[0] <= in_key_first;
      key_r[1] <= in_key_second;
      null_r  <= in_key_null_mask;
      val_r[0] <= in_value_first;
      val_r[1] <= in_value_second;
      val_r[2] <= in_value_third;
      val_r[3] <= in_value_fourth;
      vmask_r <= in_value_valid_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      hit_r <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + IW'(1);
      if (cmd.hit_from_idx) hit_r <= idx_r;
      else if (cmd.miss_add) hit_r <= IW'(cnt_r);
      if (cmd.drain_clr) cnt_r <= '0;
      else if (cmd.miss_add) cnt_r <= cnt_r + CW'(1);
    end
  end

  // a new group starts with its seen bits clear, so entries past the
  // group count never need clearing
  always_ff @(posedge clk) begin
    if (cmd.miss_add) begin
      seen_r[IW'(cnt_r)] <= '0;
    end else if (cmd.acc_upd) begin
      seen_r[hit_r] <= seen_new;
    end
    if (cmd.acc_rd_hit) seen_q <= seen_r[hit_r];
    else if (cmd.acc_rd_idx) seen_q <= seen_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.miss_add) key_mem[IW'(cnt_r)] <= {key_r[1], key_r[0]};
    if (cmd.key_rd) key_q <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_upd) acc_mem[hit_r] <= acc_new;
    if (cmd.acc_rd_hit) acc_q <= acc_mem[hit_r];
    else if (cmd.acc_rd_idx) acc_q <= acc_mem[idx_r];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_err || cmd.emit_row) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_status        <= cmd.err_code;
      out_key_first     <= '0;
      out_key_second    <= '0;
      out_result_first  <= '0;
      out_result_second <= '0;
      out_result_third  <= '0;
      out_result_fourth <= '0;
      out_last          <= 1'b1;
    end else if (cmd.emit_row) begin
      out_status        <= gbat_pkg::ST_GROUP;
      out_key_first     <= key_q[KW-1:0];
      out_key_second    <= use2 ? key_q[2*KW-1:KW] : '0;
      out_result_first  <= row_res[0];
      out_result_second <= row_res[1];
      out_result_third  <= row_res[2];
      out_result_fourth <= row_res[3];
      out_last          <= sts.idx_last;
    end
  end

  assign out_valid = out_valid_r;

`include "group_by_aggregate_table_assert.svh"

  `GBAT_CHECK(a_cnt_bound, cnt_r <= FULL_CNT, "group count above table size")
  `GBAT_CHECK(a_emit_free, (cmd.emit_row || cmd.emit_err) |-> out_free, "word overwritten")
  `GBAT_CHECK_NEXT(a_drain_clears, cmd.drain_clr, cnt_r == '0, "drain left groups behind")

endmodule

FILE: hdl/group_by_aggregate_table.sv
// group-by aggregation table: rows fold into up to MAX_GROUPS groups keyed
// on one or two signed 64-bit columns, with count, sum, min or max per slot.
// input channel: in_valid/in_stall; in_func 0 folds a row, 1 drains all
// groups in insertion order and empties the table. result channel:
// out_valid/out_stall, one word per group on a drain, or one error word.
// config: cfg_write_en, cfg_index, cfg_data; write only while idle.
// one word at a time: a fold compares the stored groups in insertion order
// until one matches, or all of them on a miss, then reads and updates the
// accumulators; the key table is one memory read one entry at a time and
// each entry needs a read and a compare. a drain reads and emits each group
// in turn; a null key or empty drain goes straight to its error word, a full
// table errors after the full scan. a successful fold makes no result word.
// reset (synchronous, rst_n low) empties the table and restores the
// register defaults; no clearing pass is needed.
// while out_stall is high the result word holds and the block waits
// before producing the next word; in_stall is high while a word is in work.
module group_by_aggregate_table #(
  parameter int MAX_GROUPS = 64,
  parameter int MAX_KEYS   = 2,
  parameter int MAX_AGGS   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic signed [63:0]  in_key_first,
  input  logic signed [63:0]  in_key_second,
  input  logic [1:0]          in_key_null_mask,
  input  logic signed [63:0]  in_value_first,
  input  logic signed [63:0]  in_value_second,
  input  logic signed [63:0]  in_value_third,
  input  logic signed [63:0]  in_value_fourth,
  input  logic [3:0]          in_value_valid_mask,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [63:0]  out_key_first,
  output logic signed [63:0]  out_key_second,
  output logic signed [63:0]  out_result_first,
  output logic signed [63:0]  out_result_second,
  output logic signed [63:0]  out_result_third,
  output logic signed [63:0]  out_result_fourth,
  output logic                out_last
);

  gbat_pkg::cmd_t cmd;
  gbat_pkg::sts_t sts;

  gbat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbat_dp #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_KEYS   (MAX_KEYS),
    .MAX_AGGS   (MAX_AGGS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_func             (in_func),
    .in_key_first        (in_key_first),
    .in_key_second       (in_key_second),
    .in_key_null_mask    (in_key_null_mask),
    .in_value_first      (in_value_first),
    .in_value_second     (in_value_second),
    .in_value_third      (in_value_third),
    .in_value_fourth     (in_value_fourth),
    .in_value_valid_mask (in_value_valid_mask),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_key_first       (out_key_first),
    .out_key_second      (out_key_second),
    .out_result_first    (out_result_first),
    .out_result_second   (out_result_second),
    .out_result_third    (out_result_third),
    .out_result_fourth   (out_result_fourth),
    .out_last            (out_last),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule
